// File: rtl/core/rbt_pkg.sv
// Package for the retry backoff throttle: widths, reset values, codes and the
// command and status types that join the controller to the datapath.
// No dependencies.
package rbt_pkg;

  localparam int WORD_BITS      = 64;
  localparam int ROUND_BITS     = 32;
  localparam int OP_BITS        = 3;
  localparam int MODE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int TIME_BITS_DEF  = 64;
  localparam int DIV_CNT_BITS   = 6;

  localparam logic [OP_BITS-1:0] OP_ADMIT    = 3'd0;
  localparam logic [OP_BITS-1:0] OP_PUBLISH  = 3'd1;
  localparam logic [OP_BITS-1:0] OP_SUCCESS  = 3'd2;
  localparam logic [OP_BITS-1:0] OP_STOP     = 3'd3;
  localparam logic [OP_BITS-1:0] OP_SNAPSHOT = 3'd4;

  localparam logic [MODE_BITS-1:0] MODE_READY    = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_COOLDOWN = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_STOPPING = 2'd2;

  localparam logic [CFG_INDEX_BITS-1:0] CFG_ENABLE = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_BASE   = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_CAP    = 2'd2;

  localparam logic                 ENABLE_RESET = 1'b1;
  localparam logic [WORD_BITS-1:0] BASE_RESET   = 64'd1000;
  localparam logic [WORD_BITS-1:0] CAP_RESET    = 64'd60000;

  localparam logic [WORD_BITS-1:0]  WORD_MAX  = {WORD_BITS{1'b1}};
  localparam logic [ROUND_BITS-1:0] ROUND_MAX = {ROUND_BITS{1'b1}};

  typedef struct packed {
    logic load;
    logic decode;
    logic pub_begin;
    logic ceil_init;
    logic ceil_step;
    logic lo_calc;
    logic span_calc;
    logic div_step;
    logic delay_sum;
    logic hint_apply;
    logic dead_calc;
    logic commit;
    logic emit;
  } rbt_cmd_t;

  typedef struct packed {
    logic [MODE_BITS-1:0] mode;
    logic                 pub_go;
    logic                 ceil_done;
    logic                 div_done;
  } rbt_sts_t;

endpackage

// File: rtl/core/rbt_if.sv
// Handshake interfaces for the command words and the result words of the
// retry backoff throttle. Depends on rbt_pkg.
interface rbt_in_if;
  logic                               valid;
  logic                               ready;
  logic [rbt_pkg::OP_BITS-1:0]        opcode;
  logic [rbt_pkg::WORD_BITS-1:0]      now_time;
  logic                               hint_valid;
  logic [rbt_pkg::WORD_BITS-1:0]      hint_delay;
  logic [rbt_pkg::WORD_BITS-1:0]      random_word;
  logic [rbt_pkg::WORD_BITS-1:0]      generation_tag;

  modport source (output valid, output opcode, output now_time, output hint_valid,
                  output hint_delay, output random_word, output generation_tag,
                  input ready);
  modport sink (input valid, input opcode, input now_time, input hint_valid,
                input hint_delay, input random_word, input generation_tag,
                output ready);
endinterface

interface rbt_out_if;
  logic                               valid;
  logic                               ready;
  logic                               admitted;
  logic [rbt_pkg::WORD_BITS-1:0]      granted_generation;
  logic [rbt_pkg::WORD_BITS-1:0]      deadline_time;
  logic [rbt_pkg::MODE_BITS-1:0]      mode_code;
  logic [rbt_pkg::WORD_BITS-1:0]      round_start_time;
  logic [rbt_pkg::WORD_BITS-1:0]      current_generation;
  logic [rbt_pkg::ROUND_BITS-1:0]     round_count;
  logic [rbt_pkg::WORD_BITS-1:0]      event_count;

  modport source (output valid, output admitted, output granted_generation,
                  output deadline_time, output mode_code, output round_start_time,
                  output current_generation, output round_count, output event_count,
                  input ready);
  modport sink (input valid, input admitted, input granted_generation,
                input deadline_time, input mode_code, input round_start_time,
                input current_generation, input round_count, input event_count,
                output ready);
endinterface

// File: rtl/core/rbt_ctrl.sv
// Sequencing state machine of the retry backoff throttle.
// Depends on rbt_pkg; drives the datapath through rbt_cmd_t and reads rbt_sts_t.
module rbt_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  output rbt_pkg::rbt_cmd_t cmd,
  input  rbt_pkg::rbt_sts_t sts
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_CINIT  = 4'd2;
  localparam logic [3:0] S_CEIL   = 4'd3;
  localparam logic [3:0] S_LO     = 4'd4;
  localparam logic [3:0] S_SPAN   = 4'd5;
  localparam logic [3:0] S_DIV    = 4'd6;
  localparam logic [3:0] S_DSUM   = 4'd7;
  localparam logic [3:0] S_HINT   = 4'd8;
  localparam logic [3:0] S_DEAD   = 4'd9;
  localparam logic [3:0] S_COMMIT = 4'd10;
  localparam logic [3:0] S_EMIT   = 4'd11;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       out_full;
  logic       out_full_next;

  assign req_ready = (state == S_IDLE);
  assign rsp_valid = out_full;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.pub_go) begin
          cmd.pub_begin = 1'b1;
          state_next    = S_CINIT;
        end else begin
          cmd.decode = 1'b1;
          state_next = S_EMIT;
        end
      end
      S_CINIT: begin
        cmd.ceil_init = 1'b1;
        state_next    = S_CEIL;
      end
      S_CEIL: begin
        if (sts.ceil_done) begin
          state_next = S_LO;
        end else begin
          cmd.ceil_step = 1'b1;
        end
      end
      S_LO: begin
        cmd.lo_calc = 1'b1;
        state_next  = S_SPAN;
      end
      S_SPAN: begin
        cmd.span_calc = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) begin
          state_next = S_DSUM;
        end
      end
      S_DSUM: begin
        cmd.delay_sum = 1'b1;
        state_next    = S_HINT;
      end
      S_HINT: begin
        cmd.hint_apply = 1'b1;
        state_next     = S_DEAD;
      end
      S_DEAD: begin
        cmd.dead_calc = 1'b1;
        state_next    = S_COMMIT;
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_full || rsp_ready) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_full_next = out_full;
    if (cmd.emit) begin
      out_full_next = 1'b1;
    end else if (rsp_ready) begin
      out_full_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      out_full <= 1'b0;
    end else begin
      state    <= state_next;
      out_full <= out_full_next;
    end
  end

endmodule

// File: rtl/core/rbt_datapath.sv
// Datapath of the retry backoff throttle: configuration and throttle state,
// the doubling ceiling, the serial jitter remainder and the result register.
// Depends on rbt_pkg; commanded by rbt_ctrl.
module rbt_datapath #(
  parameter int TIME_BITS = rbt_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rbt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rbt_pkg::WORD_BITS-1:0]       cfg_data,
  input  rbt_pkg::rbt_cmd_t                   cmd,
  output rbt_pkg::rbt_sts_t                   sts,
  input  logic [rbt_pkg::OP_BITS-1:0]         in_opcode,
  input  logic [rbt_pkg::WORD_BITS-1:0]       in_now_time,
  input  logic                                in_hint_valid,
  input  logic [rbt_pkg::WORD_BITS-1:0]       in_hint_delay,
  input  logic [rbt_pkg::WORD_BITS-1:0]       in_random_word,
  input  logic [rbt_pkg::WORD_BITS-1:0]       in_generation_tag,
  output logic                                out_admitted,
  output logic [rbt_pkg::WORD_BITS-1:0]       out_granted_generation,
  output logic [rbt_pkg::WORD_BITS-1:0]       out_deadline_time,
  output logic [rbt_pkg::MODE_BITS-1:0]       out_mode_code,
  output logic [rbt_pkg::WORD_BITS-1:0]       out_round_start_time,
  output logic [rbt_pkg::WORD_BITS-1:0]       out_current_generation,
  output logic [rbt_pkg::ROUND_BITS-1:0]      out_round_count,
  output logic [rbt_pkg::WORD_BITS-1:0]       out_event_count
);

  localparam int W  = rbt_pkg::WORD_BITS;
  localparam int RW = rbt_pkg::ROUND_BITS;
  localparam logic [W-1:0] TimeMax = rbt_pkg::WORD_MAX >> (W - TIME_BITS);

  logic                               enabled;
  logic [W-1:0]                       base;
  logic [W-1:0]                       cap;

  logic [rbt_pkg::MODE_BITS-1:0]      mode;
  logic [W-1:0]                       cooldown_end;
  logic [W-1:0]                       round_start;
  logic [RW-1:0]                      rounds;
  logic [W-1:0]                       generation_count;
  logic [W-1:0]                       publish_count;

  logic [rbt_pkg::OP_BITS-1:0]        op;
  logic [W-1:0]                       now;
  logic                               hint_on;
  logic [W-1:0]                       hint;
  logic [W-1:0]                       rnd_shift;
  logic [W-1:0]                       tag;

  logic [W-1:0]                       prior;
  logic [W-1:0]                       ceil_val;
  logic [RW-1:0]                      steps;
  logic [W-1:0]                       lo;
  logic [W-1:0]                       divisor;
  logic [W-1:0]                       rem;
  logic [rbt_pkg::DIV_CNT_BITS-1:0]   div_cnt;
  logic [W-1:0]                       delay;
  logic [W-1:0]                       deadline;
  logic                               ok;
  logic [W-1:0]                       granted;

  logic                               lapsed;
  logic [rbt_pkg::MODE_BITS-1:0]      mode_eff;
  logic [W-1:0]                       half_up;
  logic [W:0]                         rem_shift;
  logic [W:0]                         dead_sum;
  logic                               admit_ok;
  logic [W-1:0]                       admit_gen;

  assign lapsed   = (mode == rbt_pkg::MODE_COOLDOWN) && (now >= cooldown_end);
  assign mode_eff = lapsed ? rbt_pkg::MODE_READY : mode;
  assign half_up  = {1'b0, ceil_val[W-1:1]} + {{(W-1){1'b0}}, ceil_val[0]};
  assign rem_shift = {rem, rnd_shift[W-1]};
  assign dead_sum  = {1'b0, now} + {1'b0, delay};

  // A disabled throttle admits with generation zero and ignores the cooldown, but still refuses while stopping.
  assign admit_ok  = (op == rbt_pkg::OP_ADMIT) && (mode != rbt_pkg::MODE_STOPPING) &&
                     (!enabled || (mode_eff != rbt_pkg::MODE_COOLDOWN));
  assign admit_gen = (admit_ok && enabled) ? generation_count : '0;

  assign sts.mode      = mode;
  assign sts.pub_go    = (op == rbt_pkg::OP_PUBLISH) && enabled &&
                         (mode != rbt_pkg::MODE_STOPPING);
  assign sts.ceil_done = (steps == '0) || (ceil_val >= cap) || (ceil_val == '0);
  assign sts.div_done  = (div_cnt == {rbt_pkg::DIV_CNT_BITS{1'b1}});

  always_ff @(posedge clk) begin
    if (rst) begin
      enabled <= rbt_pkg::ENABLE_RESET;
      base    <= rbt_pkg::BASE_RESET;
      cap     <= rbt_pkg::CAP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        rbt_pkg::CFG_ENABLE: enabled <= cfg_data[0];
        rbt_pkg::CFG_BASE:   base    <= cfg_data;
        rbt_pkg::CFG_CAP:    cap     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op        <= in_opcode;
      now       <= in_now_time & TimeMax;
      hint_on   <= in_hint_valid;
      hint      <= in_hint_delay;
      rnd_shift <= in_random_word;
      tag       <= in_generation_tag;
    end else if (cmd.div_step) begin
      rnd_shift <= {rnd_shift[W-2:0], 1'b0};
    end
    if (cmd.ceil_init) begin
      ceil_val <= base;
      steps    <= rounds - {{(RW-1){1'b0}}, 1'b1};
    end else if (cmd.ceil_step) begin
      ceil_val <= (ceil_val > {1'b0, cap[W-1:1]}) ? cap : {ceil_val[W-2:0], 1'b0};
      steps    <= steps - {{(RW-1){1'b0}}, 1'b1};
    end
    if (cmd.lo_calc) begin
      lo <= (half_up < base) ? base : half_up;
    end
    if (cmd.span_calc) begin
      divisor <= ceil_val - lo + {{(W-1){1'b0}}, 1'b1};
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= (rem_shift >= {1'b0, divisor}) ? W'(rem_shift - {1'b0, divisor})
                                                : rem_shift[W-1:0];
      div_cnt <= div_cnt + {{(rbt_pkg::DIV_CNT_BITS-1){1'b0}}, 1'b1};
    end
    if (cmd.delay_sum) begin
      delay <= lo + rem;
    end else if (cmd.hint_apply && hint_on && (hint > delay)) begin
      delay <= hint;
    end
    if (cmd.dead_calc) begin
      deadline <= (dead_sum > {1'b0, TimeMax}) ? TimeMax : dead_sum[W-1:0];
    end
    if (cmd.emit) begin
      out_admitted           <= ok;
      out_granted_generation <= granted;
      out_deadline_time      <= cooldown_end;
      out_mode_code          <= mode;
      out_round_start_time   <= round_start;
      out_current_generation <= generation_count;
      out_round_count        <= rounds;
      out_event_count        <= publish_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= rbt_pkg::MODE_READY;
      cooldown_end     <= '0;
      round_start      <= '0;
      rounds           <= '0;
      generation_count <= '0;
      publish_count    <= '0;
      ok               <= 1'b0;
      granted          <= '0;
      prior            <= '0;
    end else begin
      if (cmd.pub_begin) begin
        ok      <= 1'b0;
        granted <= '0;
        mode    <= mode_eff;
        if (mode_eff == rbt_pkg::MODE_COOLDOWN) begin
          prior <= cooldown_end;
        end else begin
          prior       <= '0;
          round_start <= now;
          if (rounds != rbt_pkg::ROUND_MAX) begin
            rounds <= rounds + {{(RW-1){1'b0}}, 1'b1};
          end
        end
      end
      if (cmd.decode) begin
        ok      <= admit_ok;
        granted <= admit_gen;
        case (op)
          rbt_pkg::OP_ADMIT: begin
            if (enabled && (mode != rbt_pkg::MODE_STOPPING)) begin
              mode <= mode_eff;
            end
          end
          rbt_pkg::OP_SUCCESS: begin
            if (enabled && (mode != rbt_pkg::MODE_STOPPING)) begin
              mode <= mode_eff;
              if ((mode_eff == rbt_pkg::MODE_READY) && (tag == generation_count)) begin
                rounds <= '0;
              end
            end
          end
          rbt_pkg::OP_STOP: begin
            mode <= rbt_pkg::MODE_STOPPING;
          end
          default: begin
          end
        endcase
      end
      if (cmd.commit) begin
        cooldown_end <= (deadline < prior) ? prior : deadline;
        if (generation_count == rbt_pkg::WORD_MAX) begin
          mode <= rbt_pkg::MODE_STOPPING;
        end else begin
          generation_count <= generation_count + {{(W-1){1'b0}}, 1'b1};
          publish_count    <= publish_count + {{(W-1){1'b0}}, 1'b1};
          mode             <= rbt_pkg::MODE_COOLDOWN;
        end
      end
    end
  end

endmodule

// File: rtl/core/retry_backoff_throttle.sv
// Top level of the retry backoff throttle: joins the controller and the datapath.
// Depends on rbt_pkg, rbt_if, rbt_ctrl and rbt_datapath.
//
// The throttle takes one command word at a time and returns one result word for
// it. Admit, success, stop, snapshot and a publish that is ignored pass from
// acceptance through the decode and emit states to the result being offered.
// A publish that opens or extends a cooldown also passes through the ceiling,
// divider, delay, hint, deadline and commit states: the doubling loop steps
// once a cycle until the round count or the cap ends it (at most 64 steps),
// and the jitter remainder is formed by a restoring divider that retires one
// bit of the random word per cycle until all 64 bits are used. The next
// command is accepted as soon as the result is in the output register, even
// if it has not yet been taken. Configuration writes must be made while no
// command is in flight; the cap must not be set below the base delay.
module retry_backoff_throttle #(
  parameter int TIME_BITS = rbt_pkg::TIME_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [rbt_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [rbt_pkg::WORD_BITS-1:0]       cfg_data,
  rbt_in_if.sink                              req,
  rbt_out_if.source                           rsp
);

  rbt_pkg::rbt_cmd_t cmd;
  rbt_pkg::rbt_sts_t sts;

  rbt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  rbt_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cfg_write              (cfg_write),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .cmd                    (cmd),
    .sts                    (sts),
    .in_opcode              (req.opcode),
    .in_now_time            (req.now_time),
    .in_hint_valid          (req.hint_valid),
    .in_hint_delay          (req.hint_delay),
    .in_random_word         (req.random_word),
    .in_generation_tag      (req.generation_tag),
    .out_admitted           (rsp.admitted),
    .out_granted_generation (rsp.granted_generation),
    .out_deadline_time      (rsp.deadline_time),
    .out_mode_code          (rsp.mode_code),
    .out_round_start_time   (rsp.round_start_time),
    .out_current_generation (rsp.current_generation),
    .out_round_count        (rsp.round_count),
    .out_event_count        (rsp.event_count)
  );

  // Stopping is left only through reset.
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    (sts.mode == rbt_pkg::MODE_STOPPING) |=> (sts.mode == rbt_pkg::MODE_STOPPING))
    else $error("throttle left stopping without reset");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req.valid && req.ready) |=> !req.ready)
    else $error("second command accepted while one is in flight");

  a_grant_not_stopping: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.admitted) |-> (rsp.mode_code != rbt_pkg::MODE_STOPPING))
    else $error("admission reported while stopping");

  a_grant_implies_admit: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && (rsp.granted_generation != '0)) |-> rsp.admitted)
    else $error("generation granted on a refused word");

endmodule
